### rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants of the text encoding sniffer
// Marker table, verdict codes, scan phases and the step bundle that the
// top level hands to the header and scan units.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

   // sizing
   localparam int unsigned HEADER_BYTES_DEFAULT = 8;
   localparam int unsigned CNT_W                = 4;
   localparam logic [CNT_W-1:0] CNT_MAX         = 4'd15;
   localparam int unsigned MARKER_COUNT         = 5;
   localparam int unsigned MARKER_MAX_BYTES     = 8;

   // verdict codes
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_PLAIN     = 3'd0;
   localparam kind_type KIND_UTF8      = 3'd1;
   localparam kind_type KIND_UTF8_MARK = 3'd2;
   localparam kind_type KIND_UTF16BE   = 3'd3;
   localparam kind_type KIND_UTF16LE   = 3'd4;
   localparam kind_type KIND_UTF32BE   = 3'd5;
   localparam kind_type KIND_ENCRYPTED = 3'd6;

   localparam logic [15:0] PAGE_ANSI    = 16'd0;
   localparam logic [15:0] PAGE_UTF8    = 16'd65001;
   localparam logic [15:0] PAGE_UTF16BE = 16'd1201;
   localparam logic [15:0] PAGE_UTF16LE = 16'd1200;
   localparam logic [15:0] PAGE_UTF32BE = 16'd12001;

   // marker table, priority order, byte 0 in the lowest bits
   localparam logic [63:0] MARKER_BYTES [MARKER_COUNT] = '{
      64'h0001_0703_636E_6500,   // encryption marker
      64'h0000_0000_00BF_BBEF,   // UTF-8 mark
      64'h0000_0000_0000_FFFE,   // UTF-16 BE
      64'h0000_0000_0000_FEFF,   // UTF-16 LE
      64'h0000_0000_FFFE_0000    // UTF-32 BE
   };
   localparam logic [63:0] MARKER_MASK [MARKER_COUNT] = '{
      64'hFFFF_FFFF_FFFF_FFFF,
      64'h0000_0000_00FF_FFFF,
      64'h0000_0000_0000_FFFF,
      64'h0000_0000_0000_FFFF,
      64'h0000_0000_FFFF_FFFF
   };
   localparam logic [3:0] MARKER_SIZE [MARKER_COUNT] = '{
      4'd8, 4'd3, 4'd2, 4'd2, 4'd4
   };
   localparam kind_type MARKER_KIND [MARKER_COUNT] = '{
      KIND_ENCRYPTED, KIND_UTF8_MARK, KIND_UTF16BE, KIND_UTF16LE, KIND_UTF32BE
   };
   localparam logic [15:0] MARKER_PAGE [MARKER_COUNT] = '{
      PAGE_ANSI, PAGE_UTF8, PAGE_UTF16BE, PAGE_UTF16LE, PAGE_UTF32BE
   };

   // UTF-8 scan phases
   typedef enum logic [4:0] {
      PH_SEEK   = 5'b00001,
      PH_CONT   = 5'b00010,
      PH_FOLLOW = 5'b00100,
      PH_UTF8   = 5'b01000,
      PH_PLAIN  = 5'b10000
   } phase_type;

   // one byte step handed to the state units
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } step_type;

   // verdict of one chunk
   typedef struct packed {
      kind_type    kind;
      logic [15:0] page;
      logic        found;
      logic [3:0]  len;
   } verdict_type;

   // continuation bytes owed by a lead byte, 0 if not a lead
   function automatic logic [1:0] seq_len(input logic [7:0] lead);
      logic [1:0] n;
      n = 2'd0;
      if (lead >= 8'hC2 && lead <= 8'hDF) begin
         n = 2'd1;
      end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
         n = 2'd2;
      end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/core/tes_header.sv
// ----------------------------------------------------------------------------
// tes_header: header capture and leading marker match
// Keeps the first bytes of the chunk and a saturating byte count, and
// matches the marker table against them on every step.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_header
   import tes_pkg::*;
#(
   parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire step_type    step,
   output verdict_type      marker_out
);

   localparam int unsigned IDX_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   logic [7:0]       store_ff [HEADER_BYTES];
   logic [7:0]       store_in [HEADER_BYTES];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_new;
   logic             store_wr;
   logic [63:0]      hdr_view;

   // saturating count including the current byte
   assign count_new = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
   assign store_wr  = step.valid && (count_ff < CNT_W'(HEADER_BYTES));

   always_comb begin
      count_in = count_ff;
      if (step.valid) begin
         count_in = step.last ? '0 : count_new;
      end
   end

   always_comb begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
         store_in[i] = store_ff[i];
         if (store_wr && count_ff[IDX_W-1:0] == IDX_W'(i)) begin
            store_in[i] = step.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
         store_ff[i] <= store_in[i];
      end
   end

   // view of the first eight header bytes, zero beyond the store
   for (genvar g = 0; g < MARKER_MAX_BYTES; g++) begin : g_view
      if (g < HEADER_BYTES) begin : g_byte
         assign hdr_view[8*g +: 8] = store_ff[g];
      end else begin : g_pad
         assign hdr_view[8*g +: 8] = 8'h00;
      end
   end

   // marker match; a match needs the chunk strictly longer than the marker,
   // so every compared byte was stored before the current one
   always_comb begin
      marker_out = '0;
      for (int m = MARKER_COUNT - 1; m >= 0; m--) begin
         if (int'(MARKER_SIZE[m]) <= HEADER_BYTES && count_new > MARKER_SIZE[m] &&
             ((hdr_view ^ MARKER_BYTES[m]) & MARKER_MASK[m]) == 64'd0) begin
            marker_out.kind  = MARKER_KIND[m];
            marker_out.page  = MARKER_PAGE[m];
            marker_out.found = 1'b1;
            marker_out.len   = MARKER_SIZE[m];
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/tes_scan.sv
// ----------------------------------------------------------------------------
// tes_scan: UTF-8 sequence scanner
// Finds the first valid lead byte, checks its continuations and the
// overlong, surrogate and range limits, then waits for one more byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_scan
   import tes_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step,
   output logic          utf8_hit
);

   phase_type  phase_ff, phase_in, phase_nx;
   logic [7:0] lead_ff, lead_in, lead_nx;
   logic [1:0] left_ff, left_in, left_nx;
   logic       ok_ff, ok_in, ok_nx;
   logic [7:0] b;
   logic       first_cont;

   assign b          = step.data;
   assign first_cont = (left_ff == seq_len(lead_ff));

   // next scan state for this byte
   always_comb begin
      phase_nx = phase_ff;
      lead_nx  = lead_ff;
      left_nx  = left_ff;
      ok_nx    = ok_ff;
      unique case (phase_ff) inside
         PH_SEEK: begin
            if (seq_len(b) != 2'd0) begin
               lead_nx  = b;
               left_nx  = seq_len(b);
               ok_nx    = 1'b1;
               phase_nx = PH_CONT;
            end
         end
         PH_CONT: begin
            if (b[7:6] != 2'b10) begin
               ok_nx = 1'b0;
            end
            if (first_cont) begin
               if (lead_ff == 8'hE0 && b <  8'hA0) ok_nx = 1'b0;
               if (lead_ff == 8'hED && b >= 8'hA0) ok_nx = 1'b0;
               if (lead_ff == 8'hF0 && b <  8'h90) ok_nx = 1'b0;
               if (lead_ff == 8'hF4 && b >= 8'h90) ok_nx = 1'b0;
            end
            left_nx = left_ff - 2'd1;
            if (left_nx == 2'd0) begin
               phase_nx = PH_FOLLOW;
            end
         end
         PH_FOLLOW: begin
            phase_nx = ok_ff ? PH_UTF8 : PH_PLAIN;
         end
         PH_UTF8, PH_PLAIN: begin
            phase_nx = phase_ff;
         end
         default: begin
            phase_nx = PH_SEEK;
         end
      endcase
   end

   assign utf8_hit = step.valid && (phase_nx == PH_UTF8);

   // hold when idle, clear after the last byte of a chunk
   always_comb begin
      phase_in = phase_ff;
      lead_in  = lead_ff;
      left_in  = left_ff;
      ok_in    = ok_ff;
      if (step.valid) begin
         if (step.last) begin
            phase_in = PH_SEEK;
            lead_in  = '0;
            left_in  = '0;
            ok_in    = 1'b1;
         end else begin
            phase_in = phase_nx;
            lead_in  = lead_nx;
            left_in  = left_nx;
            ok_in    = ok_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         lead_ff  <= '0;
         left_ff  <= '0;
         ok_ff    <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         lead_ff  <= lead_in;
         left_ff  <= left_in;
         ok_ff    <= ok_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/text_encoding_sniffer_unit.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_unit: byte-stream text encoding detector
// Input register, header/marker and UTF-8 scan units, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one chunk byte per transaction; req_tlast marks the final
//   byte of a chunk. Only the final byte produces a transaction on rsp_*,
//   holding the verdict: kind, code page, marker flag and marker length.
//   Leading markers (encryption, UTF-8, UTF-16 BE/LE, UTF-32 BE) win over
//   the UTF-8 sequence check; all chunk state clears after each verdict.
// Timing:
//   One byte per cycle sustained unless a final byte waits for the result
//   register. A byte is held in the input register, then folded into the
//   state; a verdict passes the input and result registers to rsp_tdata.
// Reset and stall:
//   Synchronous reset empties both registers and starts a fresh chunk.
//   While rsp_tready is low a held verdict stays put; non-final bytes keep
//   flowing, and a final byte waits in the input register until the
//   result register frees, holding req_tready low while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_sniffer_unit
   import tes_pkg::*;
#(
   parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tlast,    // last_byte
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata     // [2:0] encoding_kind, [18:3] code_page,
                                          // [19] marker_found, [23:20] marker_length
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff, in_data_in;
   logic        in_last_ff, in_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        step_go;
   step_type    step;
   verdict_type marker_v;
   verdict_type verdict;
   logic        utf8_hit;

   // handshake: a final byte needs a free result register
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_go    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step_go;

   assign step.valid = step_go;
   assign step.last  = in_last_ff;
   assign step.data  = in_data_ff;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_last_in  = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
   end

   tes_header #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_header (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .marker_out (marker_v)
   );

   tes_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .utf8_hit (utf8_hit)
   );

   // verdict select: marker first, then UTF-8 detection, else plain
   always_comb begin
      verdict = '0;
      if (marker_v.found) begin
         verdict = marker_v;
      end else if (utf8_hit) begin
         verdict.kind = KIND_UTF8;
         verdict.page = PAGE_UTF8;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step_go && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = verdict;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.len, rsp_data_ff.found,
                        rsp_data_ff.page, rsp_data_ff.kind};

endmodule

`default_nettype wire
